>>> src/mcr_pkg.sv
// ============================================================================
// mcr_pkg
// Shared types and codes for the midpoint circle rasterizer.
// ============================================================================
package mcr_pkg;

    // Item kind codes
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    // Point groups of one plot, in emission order; also bit positions of the
    // group mask
    typedef enum logic [1:0] {
        GRP_AXIS,
        GRP_DIAG,
        GRP_OCT
    } mcr_group_t;

    localparam int unsigned NUM_GROUPS = 3;

    // Plot job handed from the walker to the emitter
    typedef struct packed {
        logic [NUM_GROUPS-1:0] groups;   // groups to emit, empty = one null word
        logic                  finished; // walk done after this item
    } mcr_job_ctrl_t;

endpackage

>>> src/mcr_walker.sv
// ============================================================================
// mcr_walker
// Circle walk state: latches a start word, advances one octant step per
// step word, and presents the plot job that follows from the new state.
// ============================================================================
module mcr_walker
    import mcr_pkg::*;
#(
    parameter int COORD_BITS  = 13,
    parameter int RADIUS_BITS = 11
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  logic                           kind,
    input  logic signed [COORD_BITS-1:0]   centre_x,
    input  logic signed [COORD_BITS-1:0]   centre_y,
    input  logic        [RADIUS_BITS-1:0]  radius,
    input  logic        [31:0]             colour,
    output logic signed [COORD_BITS-1:0]   job_cx,
    output logic signed [COORD_BITS-1:0]   job_cy,
    output logic        [RADIUS_BITS:0]    job_x,
    output logic        [RADIUS_BITS:0]    job_y,
    output logic        [31:0]             job_colour,
    output mcr_job_ctrl_t                  job_ctrl
);

    localparam int OFF_W = RADIUS_BITS + 1;
    localparam int DEC_W = RADIUS_BITS + 5;

    logic signed [COORD_BITS-1:0] cx_reg, cx_next;
    logic signed [COORD_BITS-1:0] cy_reg, cy_next;
    logic        [31:0]           colour_reg, colour_next;
    logic        [OFF_W-1:0]      x_reg, x_next;
    logic        [OFF_W-1:0]      y_reg, y_next;
    logic signed [DEC_W-1:0]      p_reg, p_next;
    logic                         active_reg, active_next;

    logic        [OFF_W-1:0]      x_inc, y_dec, y_step;
    logic signed [DEC_W-1:0]      p_init, p_step, two_x1, diff, two_diff1, r_ext;
    logic                         do_start, do_step;

    assign do_start = accept && (kind == KIND_START);
    assign do_step  = accept && (kind == KIND_STEP) && active_reg;

    // Step arithmetic: x advances; y drops when the decision is not negative
    assign x_inc     = x_reg + 1'b1;
    assign y_dec     = y_reg - 1'b1;
    assign two_x1    = $signed({{(DEC_W-OFF_W-1){1'b0}}, x_inc, 1'b1});
    assign diff      = $signed({{(DEC_W-OFF_W){1'b0}}, x_inc})
                     - $signed({{(DEC_W-OFF_W){1'b0}}, y_dec});
    assign two_diff1 = $signed({diff[DEC_W-2:0], 1'b1});
    assign y_step    = p_reg[DEC_W-1] ? y_reg : y_dec;
    assign p_step    = p_reg[DEC_W-1] ? (p_reg + two_x1) : (p_reg + two_diff1);

    // (5 - 4r) / 4 truncated toward zero is 1 for r = 0, 0 for r = 1 and
    // 2 - r above that
    assign r_ext  = $signed({{(DEC_W-RADIUS_BITS){1'b0}}, radius});
    assign p_init = (radius == '0) ? DEC_W'(1)
                  : ((radius == RADIUS_BITS'(1)) ? DEC_W'(0) : (DEC_W'(2) - r_ext));

    always_comb
    begin
        cx_next     = cx_reg;
        cy_next     = cy_reg;
        colour_next = colour_reg;
        x_next      = x_reg;
        y_next      = y_reg;
        p_next      = p_reg;
        if (do_start)
        begin
            cx_next     = centre_x;
            cy_next     = centre_y;
            colour_next = colour;
            x_next      = '0;
            y_next      = {1'b0, radius};
            p_next      = p_init;
        end
        else if (do_step)
        begin
            x_next = x_inc;
            y_next = y_step;
            p_next = p_step;
        end
        active_next = active_reg;
        if (do_start || do_step)
        begin
            active_next = x_next < y_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            colour_reg <= '0;
            x_reg      <= '0;
            y_reg      <= '0;
            p_reg      <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            colour_reg <= colour_next;
            x_reg      <= x_next;
            y_reg      <= y_next;
            p_reg      <= p_next;
            active_reg <= active_next;
        end
    end

    // Job from the updated state; a step with no walk running plots nothing
    always_comb
    begin
        job_cx     = cx_next;
        job_cy     = cy_next;
        job_x      = x_next;
        job_y      = y_next;
        job_colour = colour_next;
        job_ctrl   = '0;
        if (do_start || do_step)
        begin
            job_ctrl.groups[GRP_AXIS] = (x_next == '0);
            job_ctrl.groups[GRP_DIAG] = (x_next <= y_next);
            job_ctrl.groups[GRP_OCT]  = (x_next < y_next);
            job_ctrl.finished         = !active_next;
        end
        else
        begin
            job_ctrl.finished = 1'b1;
        end
    end

endmodule

>>> src/mcr_emitter.sv
// ============================================================================
// mcr_emitter
// Holds one plot job and sends its pixels, one word per cycle while the output
// is not stalled, through a registered output stage.
// ============================================================================
module mcr_emitter
    import mcr_pkg::*;
#(
    parameter int COORD_BITS  = 13,
    parameter int RADIUS_BITS = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_load,
    output logic                          job_ready,
    input  logic signed [COORD_BITS-1:0]  job_cx,
    input  logic signed [COORD_BITS-1:0]  job_cy,
    input  logic        [RADIUS_BITS:0]   job_x,
    input  logic        [RADIUS_BITS:0]   job_y,
    input  logic        [31:0]            job_colour,
    input  mcr_job_ctrl_t                 job_ctrl,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_BITS:0]    pixel_x,
    output logic signed [COORD_BITS:0]    pixel_y,
    output logic        [31:0]            pixel_colour,
    output logic                          pixel_valid,
    output logic                          last,
    output logic                          finished
);

    localparam int OFF_W = RADIUS_BITS + 1;
    localparam int PIX_W = COORD_BITS + 1;
    localparam int SUM_W = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;

    logic                         job_valid_reg;
    logic [NUM_GROUPS-1:0]        rem_reg;
    logic [1:0]                   quad_reg;
    logic                         fin_reg;
    logic signed [COORD_BITS-1:0] cx_reg, cy_reg;
    logic [OFF_W-1:0]             x_reg, y_reg;
    logic [31:0]                  colour_reg;

    logic                         out_valid_reg;
    logic signed [PIX_W-1:0]      px_reg, py_reg;
    logic [31:0]                  pcol_reg;
    logic                         pvalid_reg, last_reg, fin_out_reg;

    mcr_group_t                   cur_group;
    logic [NUM_GROUPS-1:0]        rem_after;
    logic                         is_last, load;
    logic signed [SUM_W-1:0]      xs, ys, off_x, off_y, sum_x, sum_y;

    // Lowest pending group goes first
    always_comb
    begin
        if (rem_reg[GRP_AXIS])
            cur_group = GRP_AXIS;
        else if (rem_reg[GRP_DIAG])
            cur_group = GRP_DIAG;
        else
            cur_group = GRP_OCT;
    end

    assign rem_after = rem_reg & ~(NUM_GROUPS'(1) << cur_group);
    assign is_last   = (rem_reg == '0) || ((quad_reg == 2'd3) && (rem_after == '0));
    assign load      = job_valid_reg && (!out_valid_reg || !out_stall);
    assign job_ready = !job_valid_reg || (load && is_last);

    assign xs = $signed({{(SUM_W-OFF_W){1'b0}}, x_reg});
    assign ys = $signed({{(SUM_W-OFF_W){1'b0}}, y_reg});

    always_comb
    begin
        case (cur_group)
            GRP_AXIS:
            begin
                off_x = quad_reg[1] ? (quad_reg[0] ? -ys : ys) : '0;
                off_y = quad_reg[1] ? '0 : (quad_reg[0] ? -ys : ys);
            end
            GRP_DIAG:
            begin
                off_x = quad_reg[0] ? -xs : xs;
                off_y = quad_reg[1] ? -ys : ys;
            end
            GRP_OCT:
            begin
                off_x = quad_reg[0] ? -ys : ys;
                off_y = quad_reg[1] ? -xs : xs;
            end
            default:
            begin
                off_x = '0;
                off_y = '0;
            end
        endcase
        sum_x = $signed({{(SUM_W-COORD_BITS){cx_reg[COORD_BITS-1]}}, cx_reg}) + off_x;
        sum_y = $signed({{(SUM_W-COORD_BITS){cy_reg[COORD_BITS-1]}}, cy_reg}) + off_y;
    end

    // Job control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            job_valid_reg <= 1'b0;
            rem_reg       <= '0;
            quad_reg      <= '0;
            fin_reg       <= 1'b0;
        end
        else if (job_load)
        begin
            job_valid_reg <= 1'b1;
            rem_reg       <= job_ctrl.groups;
            quad_reg      <= '0;
            fin_reg       <= job_ctrl.finished;
        end
        else if (load)
        begin
            if (is_last)
            begin
                job_valid_reg <= 1'b0;
            end
            else
            begin
                quad_reg <= quad_reg + 2'd1;
                if (quad_reg == 2'd3)
                    rem_reg <= rem_after;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (job_load)
        begin
            cx_reg     <= job_cx;
            cy_reg     <= job_cy;
            x_reg      <= job_x;
            y_reg      <= job_y;
            colour_reg <= job_colour;
        end
    end

    // Output stage: refill whenever empty or the word is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (!out_valid_reg || !out_stall)
            out_valid_reg <= job_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            if (rem_reg == '0)
            begin
                px_reg      <= '0;
                py_reg      <= '0;
                pcol_reg    <= '0;
                pvalid_reg  <= 1'b0;
                last_reg    <= 1'b1;
                fin_out_reg <= 1'b1;
            end
            else
            begin
                px_reg      <= sum_x[PIX_W-1:0];
                py_reg      <= sum_y[PIX_W-1:0];
                pcol_reg    <= colour_reg;
                pvalid_reg  <= 1'b1;
                last_reg    <= is_last;
                fin_out_reg <= fin_reg;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign pixel_x      = px_reg;
    assign pixel_y      = py_reg;
    assign pixel_colour = pcol_reg;
    assign pixel_valid  = pvalid_reg;
    assign last         = last_reg;
    assign finished     = fin_out_reg;

`ifndef SYNTHESIS
    // No new word appears once the job is gone and the last word was taken
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        (!job_valid_reg && !job_load && (!out_valid_reg || !out_stall)) |=> !out_valid_reg)
        else $error("output word with no job behind it");

    // A null word always closes its item and reports the walk done
    a_null_word: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !pvalid_reg) |-> (last_reg && fin_out_reg))
        else $error("null word without last and finished");

    // Axis points occur only at a start, which always carries diagonals
    a_axis_diag: assert property (@(posedge clk) disable iff (!rst_n)
        (job_valid_reg && rem_reg[GRP_AXIS]) |-> rem_reg[GRP_DIAG])
        else $error("axis group without diagonal group");

    // A new job is taken only when the current one ends
    a_job_handoff: assert property (@(posedge clk) disable iff (!rst_n)
        (job_load && job_valid_reg) |-> (load && is_last))
        else $error("job overwritten before its last word");
`endif

endmodule

>>> src/midpoint_circle_rasterizer_core.sv
// ============================================================================
// midpoint_circle_rasterizer_core
// Midpoint circle outline generator, one pixel word per cycle unless stalled.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall): kind 0 starts a circle from centre_x,
//   centre_y, radius and colour; kind 1 advances the walk one octant step.
//   Output channel (out_valid / out_stall): one pixel word per cycle unless
//   stalled. A start gives 8 words (radius 0) or 12; a step gives 4 or 8, or
//   one null word (pixel_valid low) when it plots nothing or no walk is running.
//   last marks the final word of an item, finished marks that the walk is over.
// Timing:
//   The walk state updates in the cycle a word is accepted; its first pixel
//   then moves from the emitter's job registers into the output register.
//   An item holds the emitter until each of its words (1 to 12) has moved
//   into the single-word output channel. The next item is accepted in the
//   cycle the previous item's last pixel moves into the output register.
// Reset:
//   rst_n clears the walk (no circle in progress) and empties both stages.
// Stall:
//   out_stall holds the output word; the emitter then pauses and in_stall
//   rises once the pending job cannot finish.
// ============================================================================
module midpoint_circle_rasterizer_core
    import mcr_pkg::*;
#(
    parameter int COORD_BITS  = 13,
    parameter int RADIUS_BITS = 11
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          kind,
    input  logic signed [COORD_BITS-1:0]  centre_x,
    input  logic signed [COORD_BITS-1:0]  centre_y,
    input  logic        [RADIUS_BITS-1:0] radius,
    input  logic        [31:0]            colour,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [COORD_BITS:0]    pixel_x,
    output logic signed [COORD_BITS:0]    pixel_y,
    output logic        [31:0]            pixel_colour,
    output logic                          pixel_valid,
    output logic                          last,
    output logic                          finished
);

    logic                         accept;
    logic                         job_ready;
    logic signed [COORD_BITS-1:0] job_cx, job_cy;
    logic        [RADIUS_BITS:0]  job_x, job_y;
    logic        [31:0]           job_colour;
    mcr_job_ctrl_t                job_ctrl;

    // Take a word only when the emitter can take its job in the same edge
    assign in_stall = !job_ready;
    assign accept   = in_valid && job_ready;

    mcr_walker #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_walker (
        .clk        (clk),
        .rst_n      (rst_n),
        .accept     (accept),
        .kind       (kind),
        .centre_x   (centre_x),
        .centre_y   (centre_y),
        .radius     (radius),
        .colour     (colour),
        .job_cx     (job_cx),
        .job_cy     (job_cy),
        .job_x      (job_x),
        .job_y      (job_y),
        .job_colour (job_colour),
        .job_ctrl   (job_ctrl)
    );

    mcr_emitter #(
        .COORD_BITS  (COORD_BITS),
        .RADIUS_BITS (RADIUS_BITS)
    ) u_emitter (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_load     (accept),
        .job_ready    (job_ready),
        .job_cx       (job_cx),
        .job_cy       (job_cy),
        .job_x        (job_x),
        .job_y        (job_y),
        .job_colour   (job_colour),
        .job_ctrl     (job_ctrl),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_colour (pixel_colour),
        .pixel_valid  (pixel_valid),
        .last         (last),
        .finished     (finished)
    );

endmodule

>>> bench/testbench.sv
// ============================================================================
// testbench
// Self-checking bench for midpoint_circle_rasterizer_core.
// A directed table walks the corner cases: steps with no circle, radius 0 and
// the largest radius at the extreme centres, a walk that ends on the diagonal
// and one that ends with an empty plot. Random circles follow, mostly full
// walks with random content and some broken ones and stray steps. Every pixel
// word is compared against an in-bench midpoint walker or a typed-in answer,
// with random idling on both channels but in the last, full-rate phase.
// ============================================================================
`timescale 1ns / 1ps

module testbench;
    import mcr_pkg::*;

    localparam int CB           = 13;
    localparam int RB           = 11;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_REPORTS  = 20;

    typedef struct packed {
        logic signed [CB:0] x;
        logic signed [CB:0] y;
        logic [31:0]        colour;
        logic               valid;
        logic               last;
        logic               finished;
    } pixel_word_t;

    // How a directed row is checked: by the walker, or by a typed-in answer
    typedef enum logic [1:0] {
        CHK_MODEL,
        CHK_NULL,
        CHK_DOT
    } row_check_t;

    typedef struct {
        logic       kind;
        int         cx;
        int         cy;
        int         r;
        logic [31:0] col;
        row_check_t chk;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 kind      = KIND_START;
    logic signed [CB-1:0] centre_x  = '0;
    logic signed [CB-1:0] centre_y  = '0;
    logic [RB-1:0]        radius    = '0;
    logic [31:0]          colour    = '0;
    logic                 out_stall = 1'b0;

    logic                 in_stall;
    logic                 out_valid;
    logic signed [CB:0]   pixel_x;
    logic signed [CB:0]   pixel_y;
    logic [31:0]          pixel_colour;
    logic                 pixel_valid;
    logic                 last;
    logic                 finished;

    midpoint_circle_rasterizer_core #(
        .COORD_BITS  (CB),
        .RADIUS_BITS (RB)
    ) i_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .kind         (kind),
        .centre_x     (centre_x),
        .centre_y     (centre_y),
        .radius       (radius),
        .colour       (colour),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .pixel_colour (pixel_colour),
        .pixel_valid  (pixel_valid),
        .last         (last),
        .finished     (finished)
    );

    // Walker state, kept apart from the block
    int          ctr_col;
    int          ctr_row;
    logic [31:0] ctr_colour;
    int          off_x;
    int          off_y;
    int          dec;
    bit          walking;

    pixel_word_t pending_pixels[$];
    stim_row_t   directed_rows[25];
    int          error_count   = 0;
    int          items_sent    = 0;
    int          cycle_count   = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    function automatic pixel_word_t null_word();
        pixel_word_t w;
        w = '0;
        w.last     = 1'b1;
        w.finished = 1'b1;
        return w;
    endfunction

    function automatic pixel_word_t pixel_at(int px, int py);
        pixel_word_t w;
        w = '0;
        w.x      = (CB+1)'(px);
        w.y      = (CB+1)'(py);
        w.colour = ctr_colour;
        w.valid  = 1'b1;
        return w;
    endfunction

    // Advance the walker by one word and list the pixel words it plots
    task automatic trace_item(input logic k, input logic signed [CB-1:0] cx,
                              input logic signed [CB-1:0] cy, input logic [RB-1:0] r,
                              input logic [31:0] col, ref pixel_word_t words[$]);
        int x;
        int y;
        words.delete();
        if (k == KIND_START)
        begin
            ctr_col    = cx;
            ctr_row    = cy;
            ctr_colour = col;
            off_x      = 0;
            off_y      = int'(r);
            dec        = (5 - 4 * int'(r)) / 4;
        end
        else if (!walking)
        begin
            words.push_back(null_word());
            return;
        end
        else
        begin
            off_x = off_x + 1;
            if (dec < 0)
                dec = dec + 2 * off_x + 1;
            else
            begin
                off_y = off_y - 1;
                dec   = dec + 2 * (off_x - off_y) + 1;
            end
        end
        walking = off_x < off_y;
        x = off_x;
        y = off_y;
        if (x == 0)
        begin
            words.push_back(pixel_at(ctr_col, ctr_row + y));
            words.push_back(pixel_at(ctr_col, ctr_row - y));
            words.push_back(pixel_at(ctr_col + y, ctr_row));
            words.push_back(pixel_at(ctr_col - y, ctr_row));
        end
        if (x <= y)
        begin
            words.push_back(pixel_at(ctr_col + x, ctr_row + y));
            words.push_back(pixel_at(ctr_col - x, ctr_row + y));
            words.push_back(pixel_at(ctr_col + x, ctr_row - y));
            words.push_back(pixel_at(ctr_col - x, ctr_row - y));
        end
        if (x < y)
        begin
            words.push_back(pixel_at(ctr_col + y, ctr_row + x));
            words.push_back(pixel_at(ctr_col - y, ctr_row + x));
            words.push_back(pixel_at(ctr_col + y, ctr_row - x));
            words.push_back(pixel_at(ctr_col - y, ctr_row - x));
        end
        if (words.size() == 0)
            words.push_back(null_word());
        else
        begin
            foreach (words[i])
                words[i].finished = !walking;
            words[words.size()-1].last = 1'b1;
        end
    endtask

    // Offer one input word, hold it until accepted, then queue its pixels
    task automatic send_word(input logic k, input logic signed [CB-1:0] cx,
                             input logic signed [CB-1:0] cy, input logic [RB-1:0] r,
                             input logic [31:0] col, input row_check_t chk);
        pixel_word_t words[$];
        pixel_word_t w;
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        centre_x <= cx;
        centre_y <= cy;
        radius   <= r;
        colour   <= col;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        items_sent++;
        trace_item(k, cx, cy, r, col, words);
        case (chk)
            CHK_NULL:
            begin
                words.delete();
                words.push_back(null_word());
            end
            CHK_DOT:
            begin
                // radius 0: eight copies of the centre, walk already over
                words.delete();
                for (int i = 0; i < 8; i++)
                begin
                    w          = pixel_at(cx, cy);
                    w.colour   = col;
                    w.finished = 1'b1;
                    w.last     = (i == 7);
                    words.push_back(w);
                end
            end
            default: ;
        endcase
        foreach (words[i])
            pending_pixels.push_back(words[i]);
    endtask

    task automatic send_random_step();
        send_word(KIND_STEP, CB'($urandom), CB'($urandom), RB'($urandom), $urandom, CHK_MODEL);
    endtask

    // Drop valid and hold off until every queued pixel has come out
    task automatic drain_pending();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (pending_pixels.size() != 0);
    endtask

    task automatic run_random_phase(input int target);
        int          stop_at;
        int          cap;
        int          n;
        int          pick;
        bit          broken;
        logic [RB-1:0] r;
        stop_at = items_sent + target;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(99) < 8)
                send_random_step();
            else
            begin
                pick = $urandom_range(99);
                if (pick < 8)
                    r = '0;
                else if (pick < 14)
                    r = RB'($urandom_range(2047, 1000));
                else
                    r = RB'($urandom_range(24, 1));
                send_word(KIND_START, CB'($urandom), CB'($urandom), r, $urandom, CHK_MODEL);
                broken = $urandom_range(99) < 15;
                if (broken)
                    cap = $urandom_range(4);
                else if (r > 100)
                    cap = $urandom_range(20, 4);
                else
                    cap = 2000;
                n = 0;
                while (walking && n < cap)
                begin
                    send_random_step();
                    n++;
                end
                if (!walking)
                    repeat ($urandom_range(2))
                        send_random_step();
            end
            if ($urandom_range(99) < 4)
                drain_pending();
        end
    endtask

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    always @(posedge clk)
    begin : watch_out
        pixel_word_t got;
        pixel_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.x        = pixel_x;
            got.y        = pixel_y;
            got.colour   = pixel_colour;
            got.valid    = pixel_valid;
            got.last     = last;
            got.finished = finished;
            if (pending_pixels.size() == 0)
            begin
                error_count++;
                if (error_count <= MAX_REPORTS)
                    $display("%0t: unexpected pixel word x=%0d y=%0d valid=%b",
                             $time, got.x, got.y, got.valid);
            end
            else
            begin
                want = pending_pixels.pop_front();
                if (got !== want)
                begin
                    error_count++;
                    if (error_count <= MAX_REPORTS)
                        $display("%0t: expected x=%0d y=%0d colour=%h valid=%b last=%b fin=%b,",
                                 $time, want.x, want.y, want.colour, want.valid, want.last,
                                 want.finished,
                                 " actual x=%0d y=%0d colour=%h valid=%b last=%b fin=%b",
                                 got.x, got.y, got.colour, got.valid,
                                 got.last, got.finished);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial
    begin
        directed_rows = '{
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_NULL },
            '{KIND_START, -4096, -4096,    0, 32'h0000_0000, CHK_DOT  },
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_NULL },
            '{KIND_START,  4095,  4095,    0, 32'hFFFF_FFFF, CHK_DOT  },
            '{KIND_START,     0,     0,    1, 32'hA5A5_A5A5, CHK_MODEL},
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_MODEL},
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_NULL },
            '{KIND_START,  4095, -4096, 2047, 32'h8000_0001, CHK_MODEL},
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_MODEL},
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_MODEL},
            '{KIND_START, -4096,  4095, 2047, 32'h7FFF_FFFE, CHK_MODEL},
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_MODEL},
            '{KIND_START,   100,  -200,    3, 32'h1234_5678, CHK_MODEL},
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_MODEL},
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_MODEL},
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_NULL },
            '{KIND_START,    -1,     1,    5, 32'hDEAD_BEEF, CHK_MODEL},
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_MODEL},
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_MODEL},
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_MODEL},
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_MODEL},
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_MODEL},
            '{KIND_START,     0,     0, 1024, 32'h0F0F_F0F0, CHK_MODEL},
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_MODEL},
            '{KIND_STEP,      0,     0,    0, 32'h0000_0000, CHK_MODEL}
        };
        ctr_col    = 0;
        ctr_row    = 0;
        ctr_colour = '0;
        off_x      = 0;
        off_y      = 0;
        dec        = 0;
        walking    = 1'b0;

        // Sender lightly idle, receiver stalling hard
        send_idle_pct = 14;
        stall_pct     = 63;
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            send_word(directed_rows[i].kind, CB'(directed_rows[i].cx),
                      CB'(directed_rows[i].cy), RB'(directed_rows[i].r),
                      directed_rows[i].col, directed_rows[i].chk);
        drain_pending();

        run_random_phase(90);
        drain_pending();

        // Swap: sender idles hard, receiver rarely stalls
        send_idle_pct = 63;
        stall_pct     = 14;
        run_random_phase(90);
        drain_pending();

        // Full rate on both sides
        send_idle_pct = 0;
        stall_pct     = 0;
        run_random_phase(85);

        drain_pending();
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (pending_pixels.size() != 0)
        begin
            error_count++;
            $display("%0t: %0d expected pixel words never arrived", $time,
                     pending_pixels.size());
        end

        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
